>>> hw/rtl/cfgtok_pkg.sv
`timescale 1ns / 1ps

package cfgtok_pkg;

	typedef enum logic [3:0] {
		ST_START,
		ST_SLASH,
		ST_LINE_CMT,
		ST_BLOCK_CMT,
		ST_BLOCK_STAR,
		ST_IDENT,
		ST_STRING,
		ST_ESCAPE,
		ST_HEX_HI,
		ST_HEX_LO,
		ST_ERROR
	} scan_state_t;

	typedef enum logic [2:0] {
		EV_CLEAR,
		EV_BYTE,
		EV_DONE,
		EV_ERROR,
		EV_END
	} ev_kind_t;

	typedef enum logic [2:0] {
		TOK_EQUAL,
		TOK_LBRACKET,
		TOK_RBRACKET,
		TOK_LBRACE,
		TOK_RBRACE,
		TOK_COMMA,
		TOK_IDENT,
		TOK_STRING
	} tok_t;

	typedef enum logic [1:0] {
		ERR_BAD_CHAR,
		ERR_BAD_ESCAPE,
		ERR_BAD_HEX,
		ERR_PREMATURE_END
	} err_t;

	typedef struct packed {
		ev_kind_t   kind;
		tok_t       ttype;
		logic [7:0] data;
		err_t       err;
	} evt_t;

	localparam int EVT_W = $bits(evt_t);

endpackage

>>> hw/rtl/config_text_tokenizer.sv
`timescale 1ns / 1ps
// An item's first result goes into the event queue, then into the output register.
// Throughput: one item per cycle while items give at most one result each and
// evt_ready is high; the output register delivers one result per cycle.
// The event queue (QUEUE_DEPTH entries) takes an item only with room for two results.
// Reset (arst_n low, asynchronous): start state, line 1, column 1, queue and output empty.

module config_text_tokenizer
	import cfgtok_pkg::*;
#(
	parameter int POS_WIDTH   = 16,
	parameter int QUEUE_DEPTH = 4
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 req_valid,
	output logic                 req_ready,
	input  logic                 req_type,
	input  logic [7:0]           char_byte,
	output logic                 evt_valid,
	input  logic                 evt_ready,
	output logic [2:0]           event_kind,
	output logic [2:0]           token_type,
	output logic [7:0]           text_byte,
	output logic [1:0]           error_code,
	output logic [POS_WIDTH-1:0] line_number,
	output logic [POS_WIDTH-1:0] column_number,
	output logic                 last
);

	localparam int ENTRY_W = EVT_W + 2 * POS_WIDTH + 1;

	logic [1:0]         push_cnt;
	logic [ENTRY_W-1:0] din0, din1, q_data;
	logic               space_ok, q_not_empty, pop;

	cfgtok_scan #(
		.POS_WIDTH (POS_WIDTH)
	) u_scan (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req_type  (req_type),
		.char_byte (char_byte),
		.space_ok  (space_ok),
		.push_cnt  (push_cnt),
		.din0      (din0),
		.din1      (din1)
	);

	cfgtok_evq #(
		.WIDTH (ENTRY_W),
		.DEPTH (QUEUE_DEPTH)
	) u_evq (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_cnt  (push_cnt),
		.din0      (din0),
		.din1      (din1),
		.pop       (pop),
		.dout      (q_data),
		.not_empty (q_not_empty),
		.space_ok  (space_ok)
	);

	cfgtok_drain #(
		.POS_WIDTH (POS_WIDTH)
	) u_drain (
		.clk           (clk),
		.arst_n        (arst_n),
		.q_not_empty   (q_not_empty),
		.q_data        (q_data),
		.pop           (pop),
		.evt_valid     (evt_valid),
		.evt_ready     (evt_ready),
		.event_kind    (event_kind),
		.token_type    (token_type),
		.text_byte     (text_byte),
		.error_code    (error_code),
		.line_number   (line_number),
		.column_number (column_number),
		.last          (last)
	);

endmodule

>>> hw/rtl/cfgtok_scan.sv
`timescale 1ns / 1ps

module cfgtok_scan
	import cfgtok_pkg::*;
#(
	parameter int POS_WIDTH = 16
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            req_valid,
	output logic                            req_ready,
	input  logic                            req_type,
	input  logic [7:0]                      char_byte,
	input  logic                            space_ok,
	output logic [1:0]                      push_cnt,
	output logic [EVT_W+2*POS_WIDTH:0]      din0,
	output logic [EVT_W+2*POS_WIDTH:0]      din1
);

	localparam logic [POS_WIDTH-1:0] POS_ONE = POS_WIDTH'(1);
	localparam logic [POS_WIDTH-1:0] POS_MAX = '1;

	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_LF     = 8'h0A;
	localparam logic [7:0] CH_CR     = 8'h0D;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_QUOTE  = 8'h22;
	localparam logic [7:0] CH_STAR   = 8'h2A;
	localparam logic [7:0] CH_COMMA  = 8'h2C;
	localparam logic [7:0] CH_DASH   = 8'h2D;
	localparam logic [7:0] CH_SLASH  = 8'h2F;
	localparam logic [7:0] CH_ZERO   = 8'h30;
	localparam logic [7:0] CH_EQUAL  = 8'h3D;
	localparam logic [7:0] CH_LBRK   = 8'h5B;
	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_RBRK   = 8'h5D;
	localparam logic [7:0] CH_UNDER  = 8'h5F;
	localparam logic [7:0] CH_LC_N   = 8'h6E;
	localparam logic [7:0] CH_LC_R   = 8'h72;
	localparam logic [7:0] CH_LC_T   = 8'h74;
	localparam logic [7:0] CH_LC_X   = 8'h78;
	localparam logic [7:0] CH_LBRACE = 8'h7B;
	localparam logic [7:0] CH_RBRACE = 8'h7D;

	typedef struct packed {
		logic [1:0] n;
		evt_t       a;
		evt_t       b;
	} start_res_t;

	scan_state_t            state_q, state_nx;
	logic [3:0]             nib_q;
	logic [POS_WIDTH-1:0]   line_q, col_q;
	logic                   take;
	logic [1:0]             ev_n;
	evt_t                   ev0, ev1;
	start_res_t             sres;

	function automatic logic is_alpha(input logic [7:0] c);
		return c inside {[8'h41:8'h5A], [8'h61:8'h7A]};
	endfunction

	function automatic logic is_ident(input logic [7:0] c);
		return is_alpha(c) || (c inside {[8'h30:8'h39]}) || c == CH_DASH || c == CH_UNDER;
	endfunction

	function automatic logic is_hex(input logic [7:0] c);
		return c inside {[8'h30:8'h39], [8'h41:8'h46], [8'h61:8'h66]};
	endfunction

	function automatic logic [3:0] hex_val(input logic [7:0] c);
		logic [7:0] v;
		if (c inside {[8'h30:8'h39]}) begin
			v = c - 8'h30;
		end else if (c inside {[8'h41:8'h46]}) begin
			v = c - 8'h37;
		end else begin
			v = c - 8'h57;
		end
		return v[3:0];
	endfunction

	function automatic evt_t mk_ev(input ev_kind_t k, input tok_t t, input logic [7:0] d,
			input err_t e);
		evt_t r;
		r.kind  = k;
		r.ttype = t;
		r.data  = d;
		r.err   = e;
		return r;
	endfunction

	function automatic scan_state_t start_next(input logic [7:0] c);
		scan_state_t s;
		if (c == CH_SLASH) begin
			s = ST_SLASH;
		end else if (c == CH_QUOTE) begin
			s = ST_STRING;
		end else if (is_alpha(c)) begin
			s = ST_IDENT;
		end else if (c inside {CH_SPACE, CH_TAB, CH_CR, CH_LF, CH_EQUAL, CH_LBRK, CH_RBRK,
				CH_LBRACE, CH_RBRACE, CH_COMMA}) begin
			s = ST_START;
		end else begin
			s = ST_ERROR;
		end
		return s;
	endfunction

	function automatic start_res_t start_ev(input logic [7:0] c);
		start_res_t r;
		r.n = 2'd1;
		r.a = mk_ev(EV_DONE, TOK_EQUAL, 8'h00, ERR_BAD_CHAR);
		r.b = mk_ev(EV_CLEAR, TOK_EQUAL, 8'h00, ERR_BAD_CHAR);
		case (c)
			CH_SPACE, CH_TAB, CH_CR, CH_LF, CH_SLASH: r.n = 2'd0;
			CH_EQUAL:  r.a.ttype = TOK_EQUAL;
			CH_LBRK:   r.a.ttype = TOK_LBRACKET;
			CH_RBRK:   r.a.ttype = TOK_RBRACKET;
			CH_LBRACE: r.a.ttype = TOK_LBRACE;
			CH_RBRACE: r.a.ttype = TOK_RBRACE;
			CH_COMMA:  r.a.ttype = TOK_COMMA;
			CH_QUOTE:  r.a = mk_ev(EV_CLEAR, TOK_STRING, 8'h00, ERR_BAD_CHAR);
			default: begin
				if (is_alpha(c)) begin
					r.n = 2'd2;
					r.a = mk_ev(EV_CLEAR, TOK_IDENT, 8'h00, ERR_BAD_CHAR);
					r.b = mk_ev(EV_BYTE, TOK_IDENT, c, ERR_BAD_CHAR);
				end else begin
					r.a = mk_ev(EV_ERROR, TOK_EQUAL, 8'h00, ERR_BAD_CHAR);
				end
			end
		endcase
		return r;
	endfunction

	assign req_ready = space_ok;
	assign take      = req_valid && space_ok;
	assign sres      = start_ev(char_byte);

	always_comb begin
		state_nx = state_q;
		if (state_q == ST_ERROR) begin
			state_nx = ST_ERROR;
		end else if (req_type) begin
			state_nx = (state_q == ST_START) ? ST_START : ST_ERROR;
		end else begin
			case (state_q)
				ST_START: state_nx = start_next(char_byte);
				ST_SLASH: begin
					if (char_byte == CH_SLASH) state_nx = ST_LINE_CMT;
					else if (char_byte == CH_STAR) state_nx = ST_BLOCK_CMT;
					else state_nx = ST_ERROR;
				end
				ST_LINE_CMT: begin
					if (char_byte == CH_LF) state_nx = ST_START;
				end
				ST_BLOCK_CMT: begin
					if (char_byte == CH_STAR) state_nx = ST_BLOCK_STAR;
				end
				ST_BLOCK_STAR: begin
					if (char_byte == CH_SLASH) state_nx = ST_START;
					else if (char_byte != CH_STAR) state_nx = ST_BLOCK_CMT;
				end
				ST_IDENT: begin
					if (!is_ident(char_byte)) state_nx = start_next(char_byte);
				end
				ST_STRING: begin
					if (char_byte == CH_QUOTE) state_nx = ST_START;
					else if (char_byte == CH_BSLASH) state_nx = ST_ESCAPE;
				end
				ST_ESCAPE: begin
					if (char_byte inside {CH_QUOTE, CH_LC_N, CH_LC_T, CH_LC_R, CH_ZERO,
							CH_BSLASH}) state_nx = ST_STRING;
					else if (char_byte == CH_LC_X) state_nx = ST_HEX_HI;
					else state_nx = ST_ERROR;
				end
				ST_HEX_HI: state_nx = is_hex(char_byte) ? ST_HEX_LO : ST_ERROR;
				ST_HEX_LO: state_nx = is_hex(char_byte) ? ST_STRING : ST_ERROR;
				default:   state_nx = ST_ERROR;
			endcase
		end
	end

	always_comb begin
		ev_n = 2'd0;
		ev0  = mk_ev(EV_CLEAR, TOK_EQUAL, 8'h00, ERR_BAD_CHAR);
		ev1  = mk_ev(EV_CLEAR, TOK_EQUAL, 8'h00, ERR_BAD_CHAR);
		if (state_q == ST_ERROR) begin
			ev_n = 2'd0;
		end else if (req_type) begin
			ev_n = 2'd1;
			if (state_q == ST_START) ev0 = mk_ev(EV_END, TOK_EQUAL, 8'h00, ERR_BAD_CHAR);
			else ev0 = mk_ev(EV_ERROR, TOK_EQUAL, 8'h00, ERR_PREMATURE_END);
		end else begin
			case (state_q)
				ST_START: begin
					ev_n = sres.n;
					ev0  = sres.a;
					ev1  = sres.b;
				end
				ST_SLASH: begin
					if (char_byte != CH_SLASH && char_byte != CH_STAR) begin
						ev_n = 2'd1;
						ev0  = mk_ev(EV_ERROR, TOK_EQUAL, 8'h00, ERR_BAD_CHAR);
					end
				end
				ST_IDENT: begin
					if (is_ident(char_byte)) begin
						ev_n = 2'd1;
						ev0  = mk_ev(EV_BYTE, TOK_IDENT, char_byte, ERR_BAD_CHAR);
					end else begin
						ev_n = 2'd1 + sres.n;
						ev0  = mk_ev(EV_DONE, TOK_IDENT, 8'h00, ERR_BAD_CHAR);
						ev1  = sres.a;
					end
				end
				ST_STRING: begin
					if (char_byte == CH_QUOTE) begin
						ev_n = 2'd1;
						ev0  = mk_ev(EV_DONE, TOK_STRING, 8'h00, ERR_BAD_CHAR);
					end else if (char_byte != CH_BSLASH) begin
						ev_n = 2'd1;
						ev0  = mk_ev(EV_BYTE, TOK_STRING, char_byte, ERR_BAD_CHAR);
					end
				end
				ST_ESCAPE: begin
					ev_n = 2'd1;
					case (char_byte)
						CH_QUOTE:  ev0 = mk_ev(EV_BYTE, TOK_STRING, CH_QUOTE, ERR_BAD_CHAR);
						CH_LC_N:   ev0 = mk_ev(EV_BYTE, TOK_STRING, CH_LF, ERR_BAD_CHAR);
						CH_LC_T:   ev0 = mk_ev(EV_BYTE, TOK_STRING, CH_TAB, ERR_BAD_CHAR);
						CH_LC_R:   ev0 = mk_ev(EV_BYTE, TOK_STRING, CH_CR, ERR_BAD_CHAR);
						CH_ZERO:   ev0 = mk_ev(EV_BYTE, TOK_STRING, 8'h00, ERR_BAD_CHAR);
						CH_BSLASH: ev0 = mk_ev(EV_BYTE, TOK_STRING, CH_BSLASH, ERR_BAD_CHAR);
						CH_LC_X:   ev_n = 2'd0;
						default:   ev0 = mk_ev(EV_ERROR, TOK_EQUAL, 8'h00, ERR_BAD_ESCAPE);
					endcase
				end
				ST_HEX_HI: begin
					if (!is_hex(char_byte)) begin
						ev_n = 2'd1;
						ev0  = mk_ev(EV_ERROR, TOK_EQUAL, 8'h00, ERR_BAD_HEX);
					end
				end
				ST_HEX_LO: begin
					ev_n = 2'd1;
					if (is_hex(char_byte)) begin
						ev0 = mk_ev(EV_BYTE, TOK_STRING, {nib_q, hex_val(char_byte)},
							ERR_BAD_CHAR);
					end else begin
						ev0 = mk_ev(EV_ERROR, TOK_EQUAL, 8'h00, ERR_BAD_HEX);
					end
				end
				default: ev_n = 2'd0;
			endcase
		end
	end

	assign push_cnt = take ? ev_n : 2'd0;
	assign din0     = {line_q, col_q, (ev_n == 2'd1), ev0};
	assign din1     = {line_q, col_q, 1'b1, ev1};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_START;
			nib_q   <= 4'h0;
			line_q  <= POS_ONE;
			col_q   <= POS_ONE;
		end else if (take) begin
			state_q <= state_nx;
			if (state_q == ST_HEX_HI && !req_type && is_hex(char_byte)) begin
				nib_q <= hex_val(char_byte);
			end
			if (state_q != ST_ERROR) begin
				if (req_type) begin
					if (state_q == ST_START) begin
						line_q <= POS_ONE;
						col_q  <= POS_ONE;
					end
				end else if (char_byte == CH_LF) begin
					if (line_q != POS_MAX) line_q <= line_q + POS_ONE;
					col_q <= POS_ONE;
				end else if (col_q != POS_MAX) begin
					col_q <= col_q + POS_ONE;
				end
			end
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_ERROR) |=> (state_q == ST_ERROR))
		else $error("scanner left the error state");

	assert property (@(posedge clk) disable iff (!arst_n)
		(line_q != '0) && (col_q != '0))
		else $error("position counter reached zero");

endmodule

>>> hw/rtl/cfgtok_evq.sv
`timescale 1ns / 1ps

module cfgtok_evq #(
	parameter int WIDTH = 49,
	parameter int DEPTH = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic [1:0]       push_cnt,
	input  logic [WIDTH-1:0] din0,
	input  logic [WIDTH-1:0] din1,
	input  logic             pop,
	output logic [WIDTH-1:0] dout,
	output logic             not_empty,
	output logic             space_ok
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] slot_q [DEPTH];
	logic [PW-1:0]    wr_ptr_q, rd_ptr_q, wr_ptr_p1;
	logic [CW-1:0]    count_q;

	function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
		return (p == PW'(DEPTH - 1)) ? '0 : p + PW'(1);
	endfunction

	assign wr_ptr_p1 = ptr_inc(wr_ptr_q);
	assign dout      = slot_q[rd_ptr_q];
	assign not_empty = (count_q != '0);
	assign space_ok  = (count_q <= CW'(DEPTH - 2));

	always_ff @(posedge clk) begin
		if (push_cnt != 2'd0) slot_q[wr_ptr_q] <= din0;
		if (push_cnt == 2'd2) slot_q[wr_ptr_p1] <= din1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push_cnt == 2'd1) wr_ptr_q <= wr_ptr_p1;
			else if (push_cnt == 2'd2) wr_ptr_q <= ptr_inc(wr_ptr_p1);
			if (pop) rd_ptr_q <= ptr_inc(rd_ptr_q);
			count_q <= count_q + CW'(push_cnt) - CW'(pop);
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> not_empty)
		else $error("pop from empty event queue");

	assert property (@(posedge clk) disable iff (!arst_n)
		(push_cnt != 2'd0) |-> (count_q <= CW'(DEPTH - 2)))
		else $error("push into event queue without room");

endmodule

>>> hw/rtl/cfgtok_drain.sv
`timescale 1ns / 1ps

module cfgtok_drain
	import cfgtok_pkg::*;
#(
	parameter int POS_WIDTH = 16
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        q_not_empty,
	input  logic [EVT_W+2*POS_WIDTH:0]  q_data,
	output logic                        pop,
	output logic                        evt_valid,
	input  logic                        evt_ready,
	output logic [2:0]                  event_kind,
	output logic [2:0]                  token_type,
	output logic [7:0]                  text_byte,
	output logic [1:0]                  error_code,
	output logic [POS_WIDTH-1:0]        line_number,
	output logic [POS_WIDTH-1:0]        column_number,
	output logic                        last
);

	localparam int ENTRY_W = EVT_W + 2 * POS_WIDTH + 1;

	logic                valid_q;
	logic [ENTRY_W-1:0]  out_q;
	evt_t                ev;

	assign pop = q_not_empty && (!valid_q || evt_ready);

	always_ff @(posedge clk) begin
		if (pop) out_q <= q_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (pop) begin
			valid_q <= 1'b1;
		end else if (evt_ready) begin
			valid_q <= 1'b0;
		end
	end

	assign ev            = out_q[EVT_W-1:0];
	assign evt_valid     = valid_q;
	assign event_kind    = ev.kind;
	assign token_type    = ev.ttype;
	assign text_byte     = ev.data;
	assign error_code    = ev.err;
	assign last          = out_q[EVT_W];
	assign column_number = out_q[EVT_W+POS_WIDTH:EVT_W+1];
	assign line_number   = out_q[ENTRY_W-1:EVT_W+POS_WIDTH+1];

endmodule
